@@ rtl/core/rmq_pkg.sv @@
// Package for the rotation matrix to quaternion core.
// Holds the default data width and the branch select codes.
package rmq_pkg;

  localparam int unsigned DataWidthDef = 32;

  // Branch select codes: which component comes from the square root.
  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_e;

endpackage

@@ rtl/core/rmq_sqrt_cell.sv @@
// One restoring square-root step: two radicand bits in, one root bit out.
// Registered cell of the square-root chain; depends on nothing but its ports.
module rmq_sqrt_cell #(
  parameter int unsigned RW = 64,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rad_i,
  input  logic [QW+1:0] rem_i,
  input  logic [QW-1:0] root_i,
  output logic [RW-1:0] rad_o,
  output logic [QW+1:0] rem_o,
  output logic [QW-1:0] root_o
);
  logic [QW+1:0] trial;
  logic [QW+1:0] rem_sh;

  assign rem_sh = {rem_i[QW-1:0], rad_i[RW-1 -: 2]};
  assign trial  = {root_i, 2'b01};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o <= {rad_i[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_o  <= rem_sh - trial;
        root_o <= {root_i[QW-2:0], 1'b1};
      end else begin
        rem_o  <= rem_sh;
        root_o <= {root_i[QW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/core/rmq_div_cell.sv @@
// One restoring division step on magnitudes: one quotient bit per cell.
// Registered cell of the divider chain; depends on nothing but its ports.
module rmq_div_cell #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] num_o,
  output logic [DW:0]   rem_o
);
  logic [DW+1:0] rem_sh;

  assign rem_sh = {rem_i, num_i[NW-1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rem_sh >= {2'b00, den_i}) begin
        rem_o <= (DW+1)'(rem_sh - {2'b00, den_i});
        num_o <= {num_i[NW-2:0], 1'b1};
      end else begin
        rem_o <= (DW+1)'(rem_sh);
        num_o <= {num_i[NW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/core/rotation_matrix_to_quaternion_core.sv @@
// Rotation matrix to quaternion core (branch-on-trace method).
// Each item passes the decode register, the square-root cells and the divider cells on its way
// to the output register.
// Throughput: one item per cycle unless stalled; after decode each stage is a square-root or divider cell.
// The whole chain advances only when the output register is free or being taken.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DataWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // m00, m10, m20, m01, m11, m21, m02, m12, m22 from the lowest bit up
  input  logic [9*DATA_WIDTH-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up
  output logic [4*DATA_WIDTH-1:0] m_axis_tdata,
  // status
  output logic                    m_axis_tuser
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = W - 2;
  localparam int unsigned EW = W + 3;          // exact sums of three entries plus one
  localparam int unsigned RW = 2 * W;          // radicand shifted by F, even width
  localparam int unsigned QW = W;              // root width
  localparam int unsigned NW = W + 2 + F - 1;  // numerator magnitude width
  localparam int unsigned NS = QW;             // square-root cells
  localparam int unsigned ND = NW;             // divider cells
  localparam int unsigned NT = 1 + NS + ND;    // stages before output register

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 0: decode ----------------
  logic signed [W-1:0] m [9];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign m[i] = s_axis_tdata[i*W +: W];
  end

  logic signed [EW-1:0] e00, e10, e20, e01, e11, e21, e02, e12, e22, one_e;
  logic signed [EW-1:0] trace, rad, n0, n1, n2;
  rmq_pkg::sel_e        sel;

  always_comb begin
    e00 = EW'(m[0]); e10 = EW'(m[1]); e20 = EW'(m[2]);
    e01 = EW'(m[3]); e11 = EW'(m[4]); e21 = EW'(m[5]);
    e02 = EW'(m[6]); e12 = EW'(m[7]); e22 = EW'(m[8]);
    one_e = EW'(1) <<< F;
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      sel = rmq_pkg::SEL_W; rad = trace + one_e;
      n0 = e21 - e12; n1 = e02 - e20; n2 = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      sel = rmq_pkg::SEL_X; rad = one_e + e00 - e11 - e22;
      n0 = e21 - e12; n1 = e01 + e10; n2 = e02 + e20;
    end else if (e11 > e22) begin
      sel = rmq_pkg::SEL_Y; rad = one_e + e11 - e00 - e22;
      n0 = e02 - e20; n1 = e01 + e10; n2 = e12 + e21;
    end else begin
      sel = rmq_pkg::SEL_Z; rad = one_e + e22 - e00 - e11;
      n0 = e10 - e01; n1 = e02 + e20; n2 = e12 + e21;
    end
  end

  // Per-stage side payload carried alongside the cells.
  typedef struct packed {
    logic                 inv;
    rmq_pkg::sel_e        sel;
    logic signed [EW-1:0] n0;
    logic signed [EW-1:0] n1;
    logic signed [EW-1:0] n2;
  } side_t;

  logic  [NT-1:0] vld_q;
  side_t          side_q [NT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NT-2:0], s_axis_tvalid};
    end
  end

  logic [RW-1:0] rad0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{inv: (rad <= 0), sel: sel, n0: n0, n1: n1, n2: n2};
      rad0_q    <= (rad <= 0) ? '0 : RW'(rad) << F;
      for (int k = 1; k < NT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------- square-root chain ----------------
  logic [RW-1:0] s_rad  [NS+1];
  logic [QW+1:0] s_rem  [NS+1];
  logic [QW-1:0] s_root [NS+1];
  assign s_rad[0]  = rad0_q;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  // Every cell holds its item while the output is stalled.
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (s_rad[i]),   .rem_i (s_rem[i]),   .root_i (s_root[i]),
      .rad_o  (s_rad[i+1]), .rem_o (s_rem[i+1]), .root_o (s_root[i+1])
    );
  end

  // ---------------- divider: three lanes of cells ----------------
  // Root h enters with the item; quotients are |n| * 2^(F-1) / h.
  logic [QW-1:0] h_q [ND+1];
  logic [NW-1:0] d_num [3][ND+1];
  logic [W:0]    d_rem [3][ND+1];

  side_t s_in;
  assign s_in = side_q[NS];

  function automatic logic [NW-1:0] mag(input logic signed [EW-1:0] v);
    logic [EW-1:0] a;
    a = v[EW-1] ? EW'(-v) : EW'(v);
    return NW'(a) << (F - 1);
  endfunction

  assign h_q[0]      = s_root[NS];
  assign d_num[0][0] = mag(s_in.n0);
  assign d_num[1][0] = mag(s_in.n1);
  assign d_num[2][0] = mag(s_in.n2);
  for (genvar l = 0; l < 3; l++) begin : g_lz
    assign d_rem[l][0] = '0;
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    logic [QW-1:0] hq;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hq <= h_q[i];
      end
    end
    assign h_q[i+1] = hq;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      rmq_div_cell #(.NW(NW), .DW(W)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .num_i (d_num[l][i]),   .rem_i (d_rem[l][i]), .den_i (h_q[i]),
        .num_o (d_num[l][i+1]), .rem_o (d_rem[l][i+1])
      );
    end
  end

  // ---------------- output register ----------------
  side_t s_out;
  assign s_out = side_q[NT-1];

  function automatic logic [W-1:0] sat(input logic [NW-1:0] q, input logic neg);
    logic [W-1:0] r;
    if (neg) begin
      r = (q > NW'(1) << (W - 1)) ? {1'b1, {(W-1){1'b0}}} : W'(-q);
    end else begin
      r = (q > (NW'(1) << (W - 1)) - 1) ? {1'b0, {(W-1){1'b1}}} : W'(q);
    end
    return r;
  endfunction

  logic [W-1:0] q0, q1, q2, dsq;
  assign dsq = h_q[ND] >> 1;
  assign q0  = sat(d_num[0][ND], s_out.n0[EW-1]);
  assign q1  = sat(d_num[1][ND], s_out.n1[EW-1]);
  assign q2  = sat(d_num[2][ND], s_out.n2[EW-1]);

  logic [4*W-1:0] tdata_d;
  always_comb begin
    unique case (s_out.sel)
      rmq_pkg::SEL_W: tdata_d = {q2, q1, q0, dsq};
      rmq_pkg::SEL_X: tdata_d = {q2, q1, dsq, q0};
      rmq_pkg::SEL_Y: tdata_d = {q2, dsq, q1, q0};
      default:        tdata_d = {dsq, q2, q1, q0};
    endcase
    if (s_out.inv) tdata_d = '0;
  end

  logic vout_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (adv) begin
      vout_q <= vld_q[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= s_out.inv;
    end
  end
  assign m_axis_tvalid = vout_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result carries nonzero data");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule

@@ tb/tb.sv @@
// Testbench for rotation_matrix_to_quaternion_core: streams matrices, predicts quaternions.
// Depends on rmq_pkg and the core; a scoreboard class holds predicted results in order.

class quat_scoreboard;
  typedef struct packed {
    logic [31:0] qz;
    logic [31:0] qy;
    logic [31:0] qx;
    logic [31:0] qw;
    logic        invalid;
  } quat_t;

  quat_t pending[$];
  int    mismatches;

  static function longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  static function logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  static function logic [31:0] div_s(longint n, longint h);
    return clamp32((n * (64'sd1 << 29)) / h);
  endfunction

  function void note_matrix(logic [287:0] mat);
    longint m[9];
    longint trace, r, h, d;
    longint dx, dy, dz, sxy, sxz, syz;
    rmq_pkg::sel_e sel;
    quat_t q;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[32*i +: 32]));
    // Index order: m00 m10 m20 m01 m11 m21 m02 m12 m22.
    trace = m[0] + m[4] + m[8];
    dx = m[5] - m[7]; dy = m[6] - m[2]; dz = m[1] - m[3];
    sxy = m[3] + m[1]; sxz = m[6] + m[2]; syz = m[7] + m[5];
    if (trace > 0) begin
      sel = rmq_pkg::SEL_W; r = trace + (64'sd1 << 30);
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = rmq_pkg::SEL_X; r = (64'sd1 << 30) + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      sel = rmq_pkg::SEL_Y; r = (64'sd1 << 30) + m[4] - m[0] - m[8];
    end else begin
      sel = rmq_pkg::SEL_Z; r = (64'sd1 << 30) + m[8] - m[0] - m[4];
    end
    q = '0;
    if (r <= 0) begin
      q.invalid = 1'b1;
    end else begin
      h = longint'(sqrt_floor(longint'(r) << 30));
      d = h >>> 1;
      case (sel)
        rmq_pkg::SEL_W: begin
          q.qw = clamp32(d); q.qx = div_s(dx, h); q.qy = div_s(dy, h); q.qz = div_s(dz, h);
        end
        rmq_pkg::SEL_X: begin
          q.qw = div_s(dx, h); q.qx = clamp32(d); q.qy = div_s(sxy, h); q.qz = div_s(sxz, h);
        end
        rmq_pkg::SEL_Y: begin
          q.qw = div_s(dy, h); q.qx = div_s(sxy, h); q.qy = clamp32(d); q.qz = div_s(syz, h);
        end
        default: begin
          q.qw = div_s(dz, h); q.qx = div_s(sxz, h); q.qy = div_s(syz, h); q.qz = clamp32(d);
        end
      endcase
    end
    pending = {pending, q};
  endfunction

  function void check_quat(logic [127:0] data, logic status);
    quat_t exp_q;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h status %b", data, status);
      return;
    end
    exp_q = pending.pop_front();
    if (data !== {exp_q.qz, exp_q.qy, exp_q.qx, exp_q.qw} || status !== exp_q.invalid) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected w %h x %h y %h z %h st %b, got w %h x %h y %h z %h st %b",
                 exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.invalid,
                 data[31:0], data[63:32], data[95:64], data[127:96], status);
    end
  endfunction
endclass

module tb;
  localparam int Latency = 1 + 32 + 63 + 1;
  localparam logic [31:0] One = 32'h4000_0000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  int send_idle_pct = 20;
  int recv_idle_pct = 71;
  quat_scoreboard quat_sb = new();

  rotation_matrix_to_quaternion_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: stalls at random and checks each taken item.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) quat_sb.check_quat(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high after an accept so items can follow back to back;
  // it drops only for idle cycles and when draining.
  task automatic send_matrix(logic [287:0] mat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    quat_sb.note_matrix(mat);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (quat_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [287:0] diag_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                                 logic [31:0] off);
    return {c, off, ~off, off, b, ~off, off, off, a};
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + 32'($signed($urandom_range(4096)) - 2048);
  endfunction

  task automatic send_random;
    logic [287:0] mat;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) mat[32*i +: 32] = $urandom;
    if (kind < 6) begin
      // Near-rotation: signed permutation matrix with small noise, covering every branch.
      logic [31:0] s0, s1, s2;
      int p;
      s0 = $urandom_range(1) ? One : -One;
      s1 = $urandom_range(1) ? One : -One;
      s2 = $urandom_range(1) ? One : -One;
      for (int i = 0; i < 9; i++) mat[32*i +: 32] = 32'($signed($urandom_range(65535)) - 32768);
      p = $urandom_range(2);
      mat[32*0 +: 32] = near(p == 0 ? s0 : 32'd0);
      mat[32*4 +: 32] = near(p == 0 ? s1 : 32'd0);
      mat[32*8 +: 32] = near(p == 0 ? s2 : 32'd0);
      if (p != 0) begin
        mat[32*1 +: 32] = near(s0); mat[32*3 +: 32] = near(s0);
        mat[32*8 +: 32] = near(s2);
      end
    end else if (kind < 8) begin
      for (int i = 0; i < 9; i++)
        mat[32*i +: 32] = 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    end
    send_matrix(mat);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: identity, each branch, ties, extremes.
    send_matrix(diag_matrix(One, One, One, 32'd0));
    send_matrix(diag_matrix(One, -One, -One, 32'd0));
    send_matrix(diag_matrix(-One, One, -One, 32'd0));
    send_matrix(diag_matrix(-One, -One, One, 32'd0));
    send_matrix(diag_matrix(32'd0, 32'd0, 32'd0, 32'h1000_0000));
    send_matrix(diag_matrix(-One, -One, -One, 32'd0));
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_matrix(diag_matrix(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_matrix(diag_matrix(32'hc000_0001, 32'hc000_0001, 32'hc000_0001, 32'h7fff_ffff));
    send_matrix(diag_matrix(32'd1, 32'd0, 32'hffff_ffff, 32'hffff_ffff));
    send_matrix({9{32'hffff_ffff}});
    send_matrix({9{32'h5555_5555}});
    send_matrix({9{32'haaaa_aaaa}});
    // Hold off until everything issued so far has come back.
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 20 : 0;
      for (int n = 0; n < 130; n++) send_random();
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (quat_sb.mismatches == 0 && quat_sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
